### hw/rtl/cht_pkg.sv
// Shared types, sizes and codes for the chained hash table.
package cht_pkg;

    // Table geometry; both counts are powers of two
    localparam int BUCKETS     = 256;
    localparam int NODES       = 256;
    localparam int KEY_BITS    = 32;
    localparam int HANDLE_BITS = 16;
    localparam int COUNT_W     = 9;

    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int NODE_W = $clog2(NODES);
    // Link field: one extra bit marks the end of a chain
    localparam int NEXT_W = NODE_W + 1;
    // Allocation count reaches NODES itself
    localparam int USED_W = NODE_W + 1;

    localparam logic [NEXT_W-1:0] END_LINK = NEXT_W'(NODES);
    localparam logic [USED_W-1:0] POOL_FULL = USED_W'(NODES);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK
    } state_t;

    // Bucket table command: read and write never fall in the same cycle
    typedef struct packed {
        logic             rd;
        logic             wr;
        logic             clr;
        logic [BKT_W-1:0] addr;
        logic [NODE_W-1:0] head;
    } bkt_cmd_t;

    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] head;
    } bkt_rsp_t;

    // One chain node as stored in the pool
    typedef struct packed {
        logic [KEY_BITS-1:0]    key;
        logic [HANDLE_BITS-1:0] handle;
        logic [NEXT_W-1:0]      next;
    } node_t;

    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [NODE_W-1:0] addr;
        node_t             data;
    } node_cmd_t;

endpackage

### hw/rtl/chained_hash_table.sv
// Chained hash table top level: request sequencer and result register.
//
//   channel  | handshake          | fields
//   ---------+--------------------+-----------------------------------
//   request  | start / busy       | op, key, value_handle
//   result   | done (1-cycle)     | status, found_handle, entry_count
//
// Insert, clear and unused codes: each request is accepted, then executed;
// done is high in the cycle after execute, in which a new start is taken.
// Search: accept, execute, then a walk over the chain nodes, one node per pool read.
// Reset clears all bucket valid bits at once; no clearing pass is needed.
// busy is high from accept until done; results cannot be held off.
module chained_hash_table
    import cht_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             op,
    input  logic [KEY_BITS-1:0]    key,
    input  logic [HANDLE_BITS-1:0] value_handle,
    output logic                   done,
    output logic [1:0]             status,
    output logic [HANDLE_BITS-1:0] found_handle,
    output logic [COUNT_W-1:0]     entry_count
);

    state_t                 state_reg, state_next;
    logic [USED_W-1:0]      used_reg, used_next;
    logic                   done_reg, done_next;
    status_t                status_reg, status_next;
    logic [HANDLE_BITS-1:0] found_reg, found_next;
    op_t                    op_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [HANDLE_BITS-1:0] handle_reg;

    bkt_cmd_t  bkt_cmd;
    bkt_rsp_t  bkt_rsp;
    node_cmd_t node_cmd;
    node_t     node_rd;
    logic      key_hit;

    cht_bucket_table u_bkt (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (bkt_cmd),
        .rsp   (bkt_rsp)
    );

    cht_node_pool u_pool (
        .clk     (clk),
        .cmd     (node_cmd),
        .rd_data (node_rd)
    );

    // Shared key comparator used on every node of a walk
    assign key_hit = (node_rd.key == key_reg);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        found_reg  <= found_next;
        if (start && !busy)
        begin
            op_reg     <= op_t'(op);
            key_reg    <= key;
            handle_reg <= value_handle;
        end
    end

    // Sequencer: next state, memory commands and result
    always_comb
    begin
        state_next    = state_reg;
        used_next     = used_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        found_next    = found_reg;
        bkt_cmd       = '0;
        bkt_cmd.addr  = key_reg[BKT_W-1:0];
        node_cmd      = '0;
        node_cmd.addr = node_rd.next[NODE_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                // Fetch bucket head as the request is taken
                if (start)
                begin
                    bkt_cmd.rd   = 1'b1;
                    bkt_cmd.addr = key[BKT_W-1:0];
                    state_next   = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next  = S_IDLE;
                done_next   = 1'b1;
                status_next = STAT_OK;
                found_next  = '0;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (used_reg == POOL_FULL)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            // Push new node at the chain head
                            node_cmd.wr          = 1'b1;
                            node_cmd.addr        = used_reg[NODE_W-1:0];
                            node_cmd.data.key    = key_reg;
                            node_cmd.data.handle = handle_reg;
                            node_cmd.data.next   = bkt_rsp.valid ?
                                                   {1'b0, bkt_rsp.head} : END_LINK;
                            bkt_cmd.wr           = 1'b1;
                            bkt_cmd.head         = used_reg[NODE_W-1:0];
                            used_next            = used_reg + 1'b1;
                        end
                    end
                    OP_SEARCH:
                    begin
                        if (!bkt_rsp.valid)
                        begin
                            status_next = STAT_MISS;
                        end
                        else
                        begin
                            node_cmd.rd   = 1'b1;
                            node_cmd.addr = bkt_rsp.head;
                            state_next    = S_WALK;
                            done_next     = 1'b0;
                        end
                    end
                    OP_CLEAR:
                    begin
                        bkt_cmd.clr = 1'b1;
                        used_next   = '0;
                    end
                    default:
                    begin
                        status_next = STAT_OK;
                    end
                endcase
            end

            S_WALK:
            begin
                // One node per cycle: compare, then follow the link
                if (key_hit)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    found_next  = node_rd.handle;
                end
                else if (node_rd.next[NODE_W])
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = STAT_MISS;
                    found_next  = '0;
                end
                else
                begin
                    node_cmd.rd = 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign found_handle = found_reg;
    assign entry_count  = COUNT_W'(used_reg);

endmodule

### hw/rtl/cht_bucket_table.sv
// Bucket table: per-bucket valid bits and chain head memory.
module cht_bucket_table
    import cht_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  bkt_cmd_t cmd,
    output bkt_rsp_t rsp
);

    logic [NODE_W-1:0]  head_mem [BUCKETS];
    logic [BUCKETS-1:0] valid_reg;
    logic [NODE_W-1:0]  rd_head_reg;
    logic               rd_valid_reg;

    // Head memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            head_mem[cmd.addr] <= cmd.head;
        end
        if (cmd.rd)
        begin
            rd_head_reg <= head_mem[cmd.addr];
        end
    end

    // Valid bits; clear empties every bucket at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
            begin
                valid_reg <= '0;
            end
            else if (cmd.wr)
            begin
                valid_reg[cmd.addr] <= 1'b1;
            end
            if (cmd.rd)
            begin
                rd_valid_reg <= valid_reg[cmd.addr];
            end
        end
    end

    assign rsp.valid = rd_valid_reg;
    assign rsp.head  = rd_head_reg;

endmodule

### hw/rtl/cht_node_pool.sv
// Node pool: key, handle and link of every chain node.
module cht_node_pool
    import cht_pkg::*;
(
    input  logic      clk,
    input  node_cmd_t cmd,
    output node_t     rd_data
);

    node_t node_mem [NODES];
    node_t rd_data_reg;

    // Single-port memory with registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            node_mem[cmd.addr] <= cmd.data;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= node_mem[cmd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
